/* src/mvt_pkg.sv */
// shared types and constants for the 4x4 matrix-vector transform unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_LANES = 4;
  localparam int NUM_COEF  = NUM_LANES * NUM_LANES;
  localparam int IDX_W     = $clog2(NUM_COEF);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + $clog2(NUM_LANES);

  localparam logic signed [DATA_W-1:0] COEF_ONE = DATA_W'(64'sd1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] SAT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_COL  = 2'd1,
    REQ_ROW  = 2'd2
  } req_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } pipe_ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } lane_res_t;

  // reset value of one coefficient: identity matrix
  function automatic logic signed [DATA_W-1:0] coef_reset(input int idx);
    logic signed [DATA_W-1:0] val;
    val = ((idx % (NUM_LANES + 1)) == 0) ? COEF_ONE : '0;
    return val;
  endfunction

endpackage

`default_nettype wire

/* src/mvt_lane.sv */
// one dot-product lane: four registered products, registered exact sum, shift and clip
// depends on mvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvt_lane (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  mvt_pkg::pipe_ctrl_t                   ctrl,
  input  wire signed [mvt_pkg::DATA_W-1:0]      coef [mvt_pkg::NUM_LANES],
  input  wire signed [mvt_pkg::DATA_W-1:0]      vec  [mvt_pkg::NUM_LANES],
  output mvt_pkg::lane_res_t                    res
);
  import mvt_pkg::*;

  logic signed [PROD_W-1:0] prod_r   [NUM_LANES];
  logic signed [PROD_W-1:0] prod_nxt [NUM_LANES];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  shifted;
  logic [SUM_W-DATA_W:0]    upper;
  logic                     in_range;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      prod_nxt[k] = PROD_W'(coef[k]) * PROD_W'(vec[k]);
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.s2_en) begin
      sum_r <= sum_nxt;
    end
  end

  // arithmetic shift floors the exact sum
  assign shifted  = sum_r >>> FRAC_BITS;
  assign upper    = shifted[SUM_W-1:DATA_W-1];
  assign in_range = (&upper) || !(|upper);

  always_comb begin
    res.sat   = !in_range;
    res.value = in_range ? shifted[DATA_W-1:0] : (upper[SUM_W-DATA_W] ? SAT_MIN : SAT_MAX);
  end

  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    res.sat |-> (res.value == SAT_MAX || res.value == SAT_MIN))
    else $error("lane flagged saturation without a clipped value");

endmodule

`default_nettype wire

/* src/mvt_merge.sv */
// merging stage: gathers the lane results and the clip flags into the output register
// depends on mvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvt_merge (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  input  mvt_pkg::lane_res_t                lane_res [mvt_pkg::NUM_LANES],
  output logic                              in_ready,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [mvt_pkg::DATA_W-1:0] out_x,
  output logic signed [mvt_pkg::DATA_W-1:0] out_y,
  output logic signed [mvt_pkg::DATA_W-1:0] out_z,
  output logic signed [mvt_pkg::DATA_W-1:0] out_w,
  output logic                              out_saturated
);
  import mvt_pkg::*;

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] val_r [NUM_LANES];
  logic                     sat_r;
  logic                     sat_nxt;

  assign in_ready = !valid_r || !out_stall;

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sat_nxt = sat_nxt | lane_res[i].sat;
    end
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        val_r[i] <= lane_res[i].value;
      end
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_x         = val_r[0];
  assign out_y         = val_r[1];
  assign out_z         = val_r[2];
  assign out_w         = val_r[3];
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

/* src/matrix_vector_transform_4x4_unit.sv */
// top level of the 4x4 matrix-vector transform: coefficient file, four lanes, merge stage
// depends on mvt_pkg, mvt_lane and mvt_merge
//
// usage:
//   input channel in_*: one transaction per accepted item (in_valid high, in_stall low).
//   a load transaction writes coefficient in_coef_index (row*4+column) and makes no result.
//   a column transaction returns M*v, a row transaction returns v*M; request code 3 is
//   taken and dropped. a load takes effect for the very next transaction.
//   output channel out_*: four Q16.16 elements, floored and clipped to 32 bits, plus
//   out_saturated when any element was clipped.
// timing: a transform result passes the product register (loaded at the edge that accepts
//   its input), then the sum register, then the output register before it shows on out_valid.
//   one transaction per cycle is sustained while out_stall stays low; each of the four lanes
//   holds four 32x32 multipliers, so all sixteen products of an item form together.
// reset: rst_n (synchronous) empties the pipeline and restores the identity matrix.
// stall: out_stall holds the output register; the pipeline keeps filling its empty
//   stages and in_stall rises only once the stage after the input is full and blocked.
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_transform_4x4_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [1:0]                         in_req_type,
  input  wire [mvt_pkg::IDX_W-1:0]          in_coef_index,
  input  wire signed [mvt_pkg::DATA_W-1:0]  in_coef_value,
  input  wire signed [mvt_pkg::DATA_W-1:0]  in_vec_x,
  input  wire signed [mvt_pkg::DATA_W-1:0]  in_vec_y,
  input  wire signed [mvt_pkg::DATA_W-1:0]  in_vec_z,
  input  wire signed [mvt_pkg::DATA_W-1:0]  in_vec_w,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [mvt_pkg::DATA_W-1:0] out_x,
  output logic signed [mvt_pkg::DATA_W-1:0] out_y,
  output logic signed [mvt_pkg::DATA_W-1:0] out_z,
  output logic signed [mvt_pkg::DATA_W-1:0] out_w,
  output logic                              out_saturated
);
  import mvt_pkg::*;

  logic signed [DATA_W-1:0] coef_r [NUM_COEF];
  logic signed [DATA_W-1:0] vec    [NUM_LANES];
  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s2_valid_r, s2_valid_nxt;
  logic                     s1_adv, s2_adv, out_adv;
  logic                     in_xfer;
  logic                     is_load, is_xform, is_row;
  pipe_ctrl_t               ctrl;
  lane_res_t                lane_res [NUM_LANES];

  assign vec[0] = in_vec_x;
  assign vec[1] = in_vec_y;
  assign vec[2] = in_vec_z;
  assign vec[3] = in_vec_w;

  always_comb begin
    is_load  = 1'b0;
    is_xform = 1'b0;
    is_row   = 1'b0;
    unique case (in_req_type)
      REQ_LOAD: is_load  = 1'b1;
      REQ_COL:  is_xform = 1'b1;
      REQ_ROW: begin
        is_xform = 1'b1;
        is_row   = 1'b1;
      end
      default: ;
    endcase
  end

  // stages fill bubbles even while the output is held
  assign s2_adv   = !s2_valid_r || out_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;
  assign in_xfer  = in_valid && s1_adv;

  assign ctrl.s1_en = s1_adv;
  assign ctrl.s2_en = s2_adv;

  always_comb begin
    s1_valid_nxt = s1_adv ? (in_xfer && is_xform) : s1_valid_r;
    s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= coef_reset(i);
      end
    end else if (in_xfer && is_load) begin
      coef_r[in_coef_index] <= in_coef_value;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic signed [DATA_W-1:0] lane_coef [NUM_LANES];

    // lane i takes row i for M*v and column i for v*M
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_sel
      localparam int ColIdx = i * NUM_LANES + k;
      localparam int RowIdx = k * NUM_LANES + i;
      assign lane_coef[k] = is_row ? coef_r[RowIdx] : coef_r[ColIdx];
    end

    mvt_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .coef  (lane_coef),
      .vec   (vec),
      .res   (lane_res[i])
    );
  end

  mvt_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (s2_valid_r),
    .lane_res      (lane_res),
    .in_ready      (out_adv),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_saturated (out_saturated)
  );

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !is_xform) |=> !s1_valid_r)
    else $error("load or unused request entered the pipeline");

  a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && is_xform) |=> s1_valid_r)
    else $error("accepted transform was lost at the first stage");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid && out_stall))
    else $error("input stalled while the pipeline had room");

endmodule

`default_nettype wire

/* bench/matrix_vector_transform_4x4_unit_tb.sv */
// self-checking bench for matrix_vector_transform_4x4_unit: directed table, then random traffic
// depends on mvt_pkg and the unit; results are compared against an exact Q16.16 transform model
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_unit_tb;
  import mvt_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 1300;
  localparam int CALM_ITEMS = 150;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [1:0]       req;
    logic [3:0]       idx;
    logic [31:0]      coef;
    logic [3:0][31:0] vec;
    logic             typed;
    logic [3:0][31:0] want;
    logic             want_sat;
  } stim_row_t;

  typedef struct {
    logic [3:0][31:0] el;
    logic             sat;
  } xform_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_req_type;
  logic [IDX_W-1:0] in_coef_index;
  logic signed [DATA_W-1:0] in_coef_value;
  logic signed [DATA_W-1:0] in_vec_x, in_vec_y, in_vec_z, in_vec_w;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_x, out_y, out_z, out_w;
  logic out_saturated;

  logic [31:0] coef_mem [16];
  xform_res_t pending_results[$];
  stim_row_t dir_tab[$];

  int err_cnt = 0;
  int n_load = 0, n_col = 0, n_row = 0, n_drop = 0;
  int n_checked = 0, n_clip = 0, n_in_stall = 0;
  bit calm = 0;
  bit hold_active = 0;
  bit hold_done = 0;

  matrix_vector_transform_4x4_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .in_vec_w      (in_vec_w),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_saturated (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // exact four-term dot products, floored by the fraction shift, then clipped to 32 bits
  function automatic xform_res_t transform_vec(input logic [1:0] req,
                                               input logic [3:0][31:0] v);
    xform_res_t r;
    logic signed [67:0] acc;
    logic signed [67:0] q;
    logic signed [63:0] prod;
    logic [31:0] m;
    r.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) begin
        m = (req == REQ_COL) ? coef_mem[i*4 + j] : coef_mem[j*4 + i];
        prod = $signed(m) * $signed(v[j]);
        acc = acc + prod;
      end
      q = acc >>> FRAC_BITS;
      if (q > 68'(SAT_MAX)) begin
        r.el[i] = SAT_MAX;
        r.sat = 1'b1;
      end else if (q < 68'(SAT_MIN)) begin
        r.el[i] = SAT_MIN;
        r.sat = 1'b1;
      end else begin
        r.el[i] = q[31:0];
      end
    end
    return r;
  endfunction

  // mostly modest Q16.16 magnitudes so that not every result clips
  function automatic logic [31:0] rand_q();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel) inside
      [0:3]: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      [4:5]: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      [6:7]: return $urandom;
      8: begin
        case ($urandom_range(0, 5))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return 32'h0;
          3:       return 32'hFFFF_FFFF;
          4:       return COEF_ONE;
          default: return -COEF_ONE;
        endcase
      end
      default:    return {($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  function automatic stim_row_t mk_row(input logic [1:0] req, input logic [3:0] idx,
                                       input logic [31:0] coef,
                                       input logic [31:0] x, y, z, w,
                                       input logic typed,
                                       input logic [31:0] ex, ey, ez, ew,
                                       input logic esat);
    stim_row_t r;
    r.req = req;
    r.idx = idx;
    r.coef = coef;
    r.vec = {w, z, y, x};
    r.typed = typed;
    r.want = {ew, ez, ey, ex};
    r.want_sat = esat;
    return r;
  endfunction

  task automatic send_item(input stim_row_t r);
    int gap;
    xform_res_t res;
    gap = 0;
    if (!calm && !hold_active && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 15);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= r.req;
    in_coef_index <= r.idx;
    in_coef_value <= r.coef;
    in_vec_x      <= r.vec[0];
    in_vec_y      <= r.vec[1];
    in_vec_z      <= r.vec[2];
    in_vec_w      <= r.vec[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (r.req) inside
      REQ_LOAD: begin
        coef_mem[r.idx] = r.coef;
        n_load++;
      end
      REQ_COL, REQ_ROW: begin
        if (r.typed) begin
          res.el = r.want;
          res.sat = r.want_sat;
        end else begin
          res = transform_vec(r.req, r.vec);
        end
        pending_results.push_back(res);
        if (r.req == REQ_COL) n_col++;
        else n_row++;
      end
      default: n_drop++;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin : check_out
    xform_res_t want;
    logic [3:0][31:0] got;
    if (rst_n && in_valid && in_stall) n_in_stall++;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_w, out_z, out_y, out_x};
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending: %h %h %h %h sat %b",
                 $time, out_x, out_y, out_z, out_w, out_saturated);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.sat) n_clip++;
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want.el[i]) begin
            $display("%0t: element %0d expected %h actual %h", $time, i, want.el[i], got[i]);
            err_cnt++;
          end
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, out_saturated);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall bursts, plus one long hold so the pipeline backs up into the input
  initial begin : receiver
    int n;
    int held;
    wait (rst_n === 1'b1);
    forever begin
      if (!calm && !hold_done && (n_load + n_col + n_row + n_drop) >= 300) begin
        hold_done = 1;
        hold_active = 1;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_active = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      n = calm ? 1 : $urandom_range(1, 15);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : main
    stim_row_t r;
    int k;
    int unsigned pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_coef_index = '0;
    in_coef_value = '0;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    in_vec_w = '0;
    out_stall = 1'b0;
    for (k = 0; k < 16; k++) coef_mem[k] = (k % 5 == 0) ? COEF_ONE : 32'h0;

    // identity after reset passes vectors through unchanged, coefficient fields ignored
    dir_tab.push_back(mk_row(REQ_COL, 4'd7, 32'hDEAD_BEEF,
      COEF_ONE, 32'hFFFE_0000, SAT_MAX, SAT_MIN,
      1, COEF_ONE, 32'hFFFE_0000, SAT_MAX, SAT_MIN, 0));
    dir_tab.push_back(mk_row(REQ_ROW, 4'd3, 32'h1234_5678,
      SAT_MIN, SAT_MAX, 32'h0, 32'hFFFF_FFFF,
      1, SAT_MIN, SAT_MAX, 32'h0, 32'hFFFF_FFFF, 0));
    dir_tab.push_back(mk_row(REQ_UNUSED, 4'd15, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_COL, 4'd0, 32'h0,
      32'h0, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 32'h0, 32'h0, 0));
    // extreme coefficients on the diagonal, vector fields on a load are don't-care
    dir_tab.push_back(mk_row(REQ_LOAD, 4'd0, SAT_MAX,
      32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_LOAD, 4'd5, SAT_MIN,
      32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_COL, 4'd0, 32'h0,
      SAT_MAX, SAT_MAX, COEF_ONE, COEF_ONE,
      1, SAT_MAX, SAT_MIN, COEF_ONE, COEF_ONE, 1));
    dir_tab.push_back(mk_row(REQ_ROW, 4'd0, 32'h0,
      SAT_MIN, COEF_ONE, 32'h0, 32'h0,
      1, SAT_MIN, SAT_MIN, 32'h0, 32'h0, 1));
    // half on m00: odd values floor toward minus infinity
    dir_tab.push_back(mk_row(REQ_LOAD, 4'd0, 32'h0000_8000,
      32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_LOAD, 4'd5, COEF_ONE,
      32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_COL, 4'd0, 32'h0,
      32'hFFFF_FFFF, 32'h1, 32'h3, 32'hFFFF_FFFD,
      1, 32'hFFFF_FFFF, 32'h1, 32'h3, 32'hFFFF_FFFD, 0));
    dir_tab.push_back(mk_row(REQ_COL, 4'd0, 32'h0,
      32'h3, 32'h0, 32'h0, 32'h0, 1, 32'h1, 32'h0, 32'h0, 32'h0, 0));
    // asymmetric matrix so column and row forms differ
    dir_tab.push_back(mk_row(REQ_LOAD, 4'd1, 32'h0002_0000,
      32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_LOAD, 4'd4, 32'hFFFF_0000,
      32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_LOAD, 4'd10, 32'h0003_8000,
      32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_COL, 4'd0, 32'h0,
      32'h0001_4000, 32'hFFFD_C000, 32'h0000_0007, 32'h0010_0001, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_ROW, 4'd0, 32'h0,
      32'h0001_4000, 32'hFFFD_C000, 32'h0000_0007, 32'h0010_0001, 0, 0, 0, 0, 0, 0));
    // bottom row all most-negative: the exact sum needs more than 64 bits
    for (k = 12; k < 16; k++)
      dir_tab.push_back(mk_row(REQ_LOAD, 4'(k), SAT_MIN,
        32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(REQ_COL, 4'd0, 32'h0,
      SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 0, 0, 0, 0, 0, 0));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) send_item(dir_tab[k]);

    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS - CALM_ITEMS) calm = 1;
      pick = $urandom_range(0, 99);
      if (pick < 15) r.req = REQ_LOAD;
      else if (pick < 55) r.req = REQ_COL;
      else if (pick < 95) r.req = REQ_ROW;
      else r.req = REQ_UNUSED;
      r.idx = 4'($urandom_range(0, 15));
      r.coef = rand_q();
      for (int j = 0; j < 4; j++) r.vec[j] = rand_q();
      r.typed = 1'b0;
      r.want = '0;
      r.want_sat = 1'b0;
      send_item(r);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d transactions: %0d loads, %0d column, %0d row, %0d dropped codes",
             n_load + n_col + n_row + n_drop, n_load, n_col, n_row, n_drop);
    $display("checked %0d results (%0d clipped), input held off on %0d cycles",
             n_checked, n_clip, n_in_stall);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* matrix_vector_transform_4x4_unit.f */
src/mvt_pkg.sv
src/mvt_lane.sv
src/mvt_merge.sv
src/matrix_vector_transform_4x4_unit.sv
bench/matrix_vector_transform_4x4_unit_tb.sv
